### rtl/mwcr_pkg.sv
package mwcr_pkg;

  // speed and timer datapath widths
  localparam int SPEED_WIDTH = 16;
  localparam int TIMER_WIDTH = 16;

  // fixed widths of the interface fields and registers
  localparam int FIELD_W = 16;
  localparam int STEP_W  = 15;

  // derived datapath widths
  localparam int WIDE_W = (SPEED_WIDTH > FIELD_W) ? SPEED_WIDTH : FIELD_W;
  localparam int SUM_W  = WIDE_W + 2;
  localparam int MUL_W  = WIDE_W + FIELD_W + 1;
  localparam int DEC_W  = WIDE_W + 2;

  // fixed-point shifts of the two products
  localparam int YAW_SHIFT   = 12;
  localparam int WHEEL_SHIFT = 8;

  // register map, word index
  typedef enum logic [2:0] {
    REG_BASE_GEOM   = 3'd0,
    REG_INV_RADIUS  = 3'd1,
    REG_MIN_SPEED   = 3'd2,
    REG_MAX_SPEED   = 3'd3,
    REG_DECEL_STEP  = 3'd4,
    REG_FIRST_TMO   = 3'd5,
    REG_REPEAT_TMO  = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  // input item kind
  typedef enum logic {
    OP_VELOCITY = 1'b0,
    OP_TICK     = 1'b1
  } op_t;

  typedef logic signed [SPEED_WIDTH-1:0] speed_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic        [FIELD_W-1:0] geom_scale;
    logic        [FIELD_W-1:0] inv_wheel_radius;
    logic signed [FIELD_W-1:0] speed_floor;
    logic signed [FIELD_W-1:0] speed_ceil;
    logic        [STEP_W-1:0]  decel_step;
    logic        [FIELD_W-1:0] first_timeout_ticks;
    logic        [FIELD_W-1:0] repeat_timeout_ticks;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic       accept_cmd;
    logic       accept_tick;
    logic       mul_yaw;
    logic       og_en;
    logic       mul_wheel;
    logic [1:0] wsel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       out_load;
  } dp_cmd_t;

  // saturate a product-width value to the speed width
  function automatic speed_t sat_mul(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] hi;
    logic signed [MUL_W-1:0] lo;
    hi = MUL_W'(speed_t'({1'b0, {(SPEED_WIDTH-1){1'b1}}}));
    lo = MUL_W'(speed_t'({1'b1, {(SPEED_WIDTH-1){1'b0}}}));
    if (v > hi) begin
      return speed_t'(hi);
    end else if (v < lo) begin
      return speed_t'(lo);
    end
    return speed_t'(v);
  endfunction

  // saturate a sum-width value to the speed width
  function automatic speed_t sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(speed_t'({1'b0, {(SPEED_WIDTH-1){1'b1}}}));
    lo = SUM_W'(speed_t'({1'b1, {(SPEED_WIDTH-1){1'b0}}}));
    if (v > hi) begin
      return speed_t'(hi);
    end else if (v < lo) begin
      return speed_t'(lo);
    end
    return speed_t'(v);
  endfunction

endpackage

### rtl/mwcr_ctrl.sv
module mwcr_ctrl
  import mwcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_op,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YAW,
    S_OG,
    S_WHEEL,
    S_POST
  } state_t;

  state_t     state_r;
  logic [2:0] idx_r;
  logic       out_valid_r;
  logic       accept;
  logic       post_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign post_ok    = (state_r == S_POST) && (!out_valid_r || out_tready);

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.accept_cmd  = accept && (op_t'(in_op) == OP_VELOCITY);
    cmd.accept_tick = accept && (op_t'(in_op) == OP_TICK);
    cmd.mul_yaw     = (state_r == S_YAW);
    cmd.og_en       = (state_r == S_OG);
    cmd.mul_wheel   = (state_r == S_WHEEL) && !idx_r[2];
    cmd.wsel        = idx_r[1:0];
    cmd.wr_en       = (state_r == S_WHEEL) && (idx_r != 3'd0);
    cmd.wr_sel      = 2'(idx_r - 3'd1);
    cmd.out_load    = post_ok;
  end

  // sequencer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (post_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (op_t'(in_op) == OP_VELOCITY) ? S_YAW : S_POST;
          end
        end
        S_YAW: begin
          state_r <= S_OG;
        end
        S_OG: begin
          idx_r   <= '0;
          state_r <= S_WHEEL;
        end
        S_WHEEL: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r[2]) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (post_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mwcr_dp.sv
module mwcr_dp
  import mwcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  dp_cmd_t              cmd,
  input  logic [3*FIELD_W-1:0] in_data,
  output logic [FIELD_W-1:0]   out_front_left,
  output logic [FIELD_W-1:0]   out_front_right,
  output logic [FIELD_W-1:0]   out_rear_left,
  output logic [FIELD_W-1:0]   out_rear_right,
  output logic                 out_timer_armed
);

  logic signed [FIELD_W-1:0]     vx_r;
  logic signed [FIELD_W-1:0]     vy_r;
  logic signed [FIELD_W-1:0]     yaw_r;
  speed_t                        og_r;
  logic signed [MUL_W-1:0]       prod_r;
  speed_t                        wheel_r [4];
  logic        [TIMER_WIDTH-1:0] cnt_r;
  logic                          armed_r;
  logic        [FIELD_W-1:0]     out_r [4];
  logic                          out_armed_r;

  logic signed [WIDE_W-1:0]  mul_a;
  logic signed [FIELD_W:0]   mul_b;
  logic signed [SUM_W-1:0]   sum_ab;
  speed_t                    sat_a;
  logic signed [SUM_W-1:0]   sum_b;
  speed_t                    sat_b;
  speed_t                    wheel_raw;
  logic signed [WIDE_W-1:0]  wheel_cl;
  speed_t                    dec_v [4];
  logic                      any_nz;

  // wheel sum: vx -/+ vy -/+ og, plus sign on vy for wheels 1 and 2, on og for 1 and 3
  always_comb begin
    if (cmd.wsel == 2'd1 || cmd.wsel == 2'd2) begin
      sum_ab = SUM_W'(vx_r) + SUM_W'(vy_r);
    end else begin
      sum_ab = SUM_W'(vx_r) - SUM_W'(vy_r);
    end
    sat_a = sat_sum(sum_ab);
    if (cmd.wsel[0]) begin
      sum_b = SUM_W'(sat_a) + SUM_W'(og_r);
    end else begin
      sum_b = SUM_W'(sat_a) - SUM_W'(og_r);
    end
    sat_b = sat_sum(sum_b);
  end

  // shared multiplier operands
  always_comb begin
    if (cmd.mul_yaw) begin
      mul_a = WIDE_W'(yaw_r);
      mul_b = $signed({1'b0, cfg.geom_scale});
    end else begin
      mul_a = WIDE_W'(sat_b);
      mul_b = $signed({1'b0, cfg.inv_wheel_radius});
    end
  end

  // scale, saturate and clamp to the speed limits, max wins on inverted limits
  always_comb begin
    wheel_raw = sat_mul(prod_r >>> WHEEL_SHIFT);
    wheel_cl  = WIDE_W'(wheel_raw);
    if (wheel_cl < WIDE_W'(cfg.speed_floor)) begin
      wheel_cl = WIDE_W'(cfg.speed_floor);
    end
    if (wheel_cl > WIDE_W'(cfg.speed_ceil)) begin
      wheel_cl = WIDE_W'(cfg.speed_ceil);
    end
  end

  // one deceleration step on all four wheels
  always_comb begin
    logic signed [DEC_W-1:0] v;
    logic signed [DEC_W-1:0] mag;
    logic signed [DEC_W-1:0] st;
    any_nz = 1'b0;
    st     = $signed(DEC_W'({1'b0, cfg.decel_step}));
    for (int i = 0; i < 4; i++) begin
      v   = DEC_W'(wheel_r[i]);
      mag = (v < 0) ? -v : v;
      if (mag > st) begin
        v = (v > 0) ? v - st : v + st;
      end else begin
        v = '0;
      end
      dec_v[i] = speed_t'(v);
      if (v != 0) begin
        any_nz = 1'b1;
      end
    end
  end

  // operand capture and products
  always_ff @(posedge clk) begin
    if (cmd.accept_cmd) begin
      vx_r  <= in_data[FIELD_W-1:0];
      vy_r  <= in_data[2*FIELD_W-1:FIELD_W];
      yaw_r <= in_data[3*FIELD_W-1:2*FIELD_W];
    end
    if (cmd.mul_yaw || cmd.mul_wheel) begin
      prod_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end
    if (cmd.og_en) begin
      og_r <= sat_mul(prod_r >>> YAW_SHIFT);
    end
  end

  // wheel speeds and timeout timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        wheel_r[i] <= '0;
      end
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        wheel_r[cmd.wr_sel] <= speed_t'(wheel_cl);
      end
      if (cmd.accept_cmd) begin
        cnt_r   <= TIMER_WIDTH'(cfg.first_timeout_ticks);
        armed_r <= 1'b1;
      end else if (cmd.accept_tick && armed_r) begin
        if (cnt_r > TIMER_WIDTH'(1)) begin
          cnt_r <= cnt_r - TIMER_WIDTH'(1);
        end else begin
          for (int i = 0; i < 4; i++) begin
            wheel_r[i] <= dec_v[i];
          end
          if (any_nz) begin
            cnt_r <= TIMER_WIDTH'(cfg.repeat_timeout_ticks);
          end else begin
            cnt_r   <= '0;
            armed_r <= 1'b0;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < 4; i++) begin
        out_r[i] <= FIELD_W'(wheel_r[i]);
      end
      out_armed_r <= armed_r;
    end
  end

  assign out_front_left  = out_r[0];
  assign out_front_right = out_r[1];
  assign out_rear_left   = out_r[2];
  assign out_rear_right  = out_r[3];
  assign out_timer_armed = out_armed_r;

endmodule

### rtl/mecanum_wheel_command_ramp.sv
// Mecanum wheel command block with timeout ramp-down. A velocity command beat
// (in_tuser = 0) yields four wheel speeds, (vx -/+ vy -/+ yaw*geometry) times the
// reciprocal wheel radius, saturated and clamped to min/max speed, and arms the
// timeout; a tick beat (in_tuser = 1) counts the timeout down and, on expiry,
// steps every wheel toward zero by decel_step. Each input beat gives one output
// beat with the current wheel speeds and the armed flag. Items are handled one
// at a time: a command passes through the yaw, og and wheel states (one shared
// 16x16 multiplier forms the yaw product and then the four wheel products in
// turn) and a tick goes straight to the post state, where the result register
// is loaded once the previous result has been taken. A new beat is taken as
// soon as the previous result is in the output register, even while that result
// waits for out_tready.
module mecanum_wheel_command_ramp
  import mwcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vel_x [15:0], vel_y [31:16], yaw_rate [47:32]
  input  logic        in_tuser,   // op [0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // front_left, front_right, rear_left, rear_right,
                                  // timer_armed [64], zero fill
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t         cfg_r;
  dp_cmd_t      cmd;
  logic         wr_en;
  reg_idx_t     widx;
  logic [FIELD_W-1:0] fl;
  logic [FIELD_W-1:0] fr;
  logic [FIELD_W-1:0] rl;
  logic [FIELD_W-1:0] rr;
  logic         armed;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.geom_scale           <= 16'd819;
      cfg_r.inv_wheel_radius     <= 16'd5120;
      cfg_r.speed_floor          <= -16'sd2560;
      cfg_r.speed_ceil           <= 16'sd2560;
      cfg_r.decel_step           <= 15'd128;
      cfg_r.first_timeout_ticks  <= 16'd100;
      cfg_r.repeat_timeout_ticks <= 16'd50;
    end else if (wr_en) begin
      unique case (widx)
        REG_BASE_GEOM:  cfg_r.geom_scale           <= pwdata[15:0];
        REG_INV_RADIUS: cfg_r.inv_wheel_radius     <= pwdata[15:0];
        REG_MIN_SPEED:  cfg_r.speed_floor          <= pwdata[15:0];
        REG_MAX_SPEED:  cfg_r.speed_ceil           <= pwdata[15:0];
        REG_DECEL_STEP: cfg_r.decel_step           <= pwdata[14:0];
        REG_FIRST_TMO:  cfg_r.first_timeout_ticks  <= pwdata[15:0];
        REG_REPEAT_TMO: cfg_r.repeat_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (widx)
      REG_BASE_GEOM:  prdata = {16'd0, cfg_r.geom_scale};
      REG_INV_RADIUS: prdata = {16'd0, cfg_r.inv_wheel_radius};
      REG_MIN_SPEED:  prdata = {16'd0, cfg_r.speed_floor};
      REG_MAX_SPEED:  prdata = {16'd0, cfg_r.speed_ceil};
      REG_DECEL_STEP: prdata = {17'd0, cfg_r.decel_step};
      REG_FIRST_TMO:  prdata = {16'd0, cfg_r.first_timeout_ticks};
      REG_REPEAT_TMO: prdata = {16'd0, cfg_r.repeat_timeout_ticks};
      default:        prdata = '0;
    endcase
  end

  mwcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mwcr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .in_data         (in_tdata),
    .out_front_left  (fl),
    .out_front_right (fr),
    .out_rear_left   (rl),
    .out_rear_right  (rr),
    .out_timer_armed (armed)
  );

  // result beat packing
  assign out_tdata = {7'd0, armed, rr, rl, fr, fl};

endmodule
